FILE: rtl/core/fasi_pkg.sv
package fasi_pkg;

  localparam int STEP_BITS_DEF = 16;
  localparam int AXES_DEF      = 4;

  localparam int LEN_W       = 32;
  localparam int SCALE_W     = 32;
  localparam int LEN_LANES   = 4;
  localparam int REV_W       = 4;
  localparam int SECTIONS    = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 32'h0001_0000;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_SCALE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE_MASK = 1'b1;

  localparam logic [1:0] SECT_0   = 2'd0;
  localparam logic [1:0] SECT_1   = 2'd1;
  localparam logic [1:0] SECT_2   = 2'd2;
  localparam logic [1:0] SECT_ALL = 2'd3;

  typedef struct packed {
    logic                    opcode;
    logic [1:0]              section;
    logic signed [LEN_W-1:0] length_a;
    logic signed [LEN_W-1:0] length_b;
    logic signed [LEN_W-1:0] length_c;
    logic signed [LEN_W-1:0] length_d;
  } in_item_t;

  typedef struct packed {
    logic [SECTIONS-1:0] enable_mask;
    logic [REV_W-1:0]    dir_mask;
    logic [REV_W-1:0]    step_mask;
    logic                last_step;
  } out_item_t;

endpackage

FILE: rtl/core/fasi_scale.sv
module fasi_scale #(
  parameter int STEP_BITS = fasi_pkg::STEP_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              load_en,
  input  logic signed [fasi_pkg::LEN_W-1:0] length,
  input  logic [fasi_pkg::SCALE_W-1:0]      scale,
  output logic [STEP_BITS-1:0]              mag,
  output logic                              neg
);
  import fasi_pkg::*;

  localparam int PROD_W = LEN_W + SCALE_W;

  logic [LEN_W-1:0]  len_mag_w;
  logic [PROD_W-1:0] prod_w;
  logic [LEN_W-1:0]  whole_r;
  logic              neg_r;
  logic              over_w;

  // The most negative length maps to its own bit pattern, which read
  // unsigned is the correct magnitude.
  assign len_mag_w = length[LEN_W-1] ? (~length + LEN_W'(1)) : length;
  assign prod_w    = PROD_W'(len_mag_w) * PROD_W'(scale);

  always_ff @(posedge clk) begin
    if (load_en) begin
      whole_r <= prod_w[PROD_W-1:SCALE_W];
      neg_r   <= length[LEN_W-1];
    end
  end

  assign over_w = |whole_r[LEN_W-1:STEP_BITS];
  assign mag    = over_w ? {STEP_BITS{1'b1}} : whole_r[STEP_BITS-1:0];
  assign neg    = neg_r;

endmodule

FILE: rtl/core/four_axis_step_interpolator_top.sv
// A tick request passes the request register, then its result the output register.
// Throughput: one request per cycle, loads and ticks alike; the input stage
// holds off only while the output register is full and stalled.
// A load takes the same two stages (multiply, then saturate and maximum).
// Reset is synchronous and active low: step scale 1.0, no reversal, idle.
module four_axis_step_interpolator_top #(
  parameter int STEP_BITS = fasi_pkg::STEP_BITS_DEF,
  parameter int AXES      = fasi_pkg::AXES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  fasi_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output fasi_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fasi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fasi_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import fasi_pkg::*;

  localparam int TGT_W = STEP_BITS + 1;
  localparam int ACC_W = STEP_BITS + 2;

  logic [SCALE_W-1:0] scale_r;
  logic [REV_W-1:0]   rev_r;

  logic               s1_valid_r;
  logic               s1_op_r;
  logic [1:0]         s1_sect_r;

  logic signed [TGT_W-1:0] tgt_r [AXES];
  logic signed [ACC_W-1:0] acc_r [AXES];
  logic [STEP_BITS-1:0]    total_r;
  logic [STEP_BITS-1:0]    done_r;
  logic [1:0]              sect_r;
  logic                    busy_r;

  logic                    out_valid_r;
  out_item_t               out_data_r;

  logic                    in_acc;
  logic                    load_en;
  logic                    has_result;
  logic                    out_free;
  logic                    s1_go;
  logic                    s1_open;

  logic signed [LEN_W-1:0] lengths_w [LEN_LANES];
  logic [STEP_BITS-1:0]    mag_w [AXES];
  logic                    neg_w [AXES];
  logic [STEP_BITS-1:0]    max_w;
  logic signed [TGT_W-1:0] tgt_nxt [AXES];

  logic signed [ACC_W-1:0] acc_nxt [AXES];
  logic [AXES-1:0]         fwd_w;
  logic [AXES-1:0]         back_w;
  logic [STEP_BITS-1:0]    done_nxt;
  logic                    last_w;
  out_item_t               res_w;

  // ---------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------
  assign has_result = s1_valid_r && (s1_op_r == OP_TICK) && busy_r;
  assign out_free   = !out_valid_r || !out_stall;
  assign s1_go      = s1_valid_r && (!has_result || out_free);
  assign s1_open    = !s1_valid_r || s1_go;
  assign in_stall   = !s1_open;
  assign in_acc     = in_valid && s1_open;
  assign load_en    = in_acc && (in_data.opcode == OP_LOAD);

  assign cfg_ready  = 1'b1;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
      rev_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STEP_SCALE:   scale_r <= cfg_data[SCALE_W-1:0];
        REG_REVERSE_MASK: rev_r   <= cfg_data[REV_W-1:0];
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Stage one: request register and per-axis scaling multiply
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_open) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r   <= in_data.opcode;
      s1_sect_r <= in_data.section;
    end
  end

  assign lengths_w[0] = in_data.length_a;
  assign lengths_w[1] = in_data.length_b;
  assign lengths_w[2] = in_data.length_c;
  assign lengths_w[3] = in_data.length_d;

  for (genvar g = 0; g < AXES; g++) begin : g_axis
    if (g < LEN_LANES) begin : g_scaled
      fasi_scale #(
        .STEP_BITS(STEP_BITS)
      ) u_scale (
        .clk    (clk),
        .load_en(load_en),
        .length (lengths_w[g]),
        .scale  (scale_r),
        .mag    (mag_w[g]),
        .neg    (neg_w[g])
      );
    end else begin : g_unused
      // Axes past the fourth have no length field and never move.
      assign mag_w[g] = '0;
      assign neg_w[g] = 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // Stage two: load setup or one interpolation tick
  // ---------------------------------------------------------------------
  always_comb begin
    max_w = '0;
    for (int i = 0; i < AXES; i++) begin
      if (mag_w[i] > max_w) begin
        max_w = mag_w[i];
      end
      tgt_nxt[i] = neg_w[i] ? (~{1'b0, mag_w[i]} + TGT_W'(1)) : {1'b0, mag_w[i]};
    end
  end

  always_comb begin
    logic signed [ACC_W-1:0] n_ext;
    logic signed [ACC_W-1:0] sum;
    n_ext = signed'({2'b00, total_r});
    for (int i = 0; i < AXES; i++) begin
      sum = acc_r[i] + signed'({tgt_r[i][TGT_W-1], tgt_r[i]});
      fwd_w[i]  = 1'b0;
      back_w[i] = 1'b0;
      if (sum >= n_ext) begin
        fwd_w[i]   = 1'b1;
        acc_nxt[i] = sum - n_ext;
      end else if (sum < 0) begin
        back_w[i]  = 1'b1;
        acc_nxt[i] = sum + n_ext;
      end else begin
        acc_nxt[i] = sum;
      end
    end
  end

  assign done_nxt = done_r + STEP_BITS'(1);
  assign last_w   = ({1'b0, done_nxt} >= {1'b0, total_r});

  always_comb begin
    res_w = '0;
    unique case (sect_r)
      SECT_0:   res_w.enable_mask = 3'b001;
      SECT_1:   res_w.enable_mask = 3'b010;
      SECT_2:   res_w.enable_mask = 3'b100;
      SECT_ALL: res_w.enable_mask = 3'b111;
    endcase
    for (int i = 0; i < AXES; i++) begin
      if (i < REV_W) begin
        res_w.dir_mask[i]  = rev_r[i] ^ ~back_w[i];
        res_w.step_mask[i] = fwd_w[i] | back_w[i];
      end
    end
    res_w.last_step = last_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AXES; i++) begin
        tgt_r[i] <= '0;
        acc_r[i] <= '0;
      end
      total_r <= '0;
      done_r  <= '0;
      sect_r  <= SECT_0;
      busy_r  <= 1'b0;
    end else if (s1_go) begin
      if (s1_op_r == OP_LOAD) begin
        for (int i = 0; i < AXES; i++) begin
          tgt_r[i] <= tgt_nxt[i];
          acc_r[i] <= '0;
        end
        total_r <= max_w;
        done_r  <= '0;
        sect_r  <= s1_sect_r;
        busy_r  <= (max_w != '0);
      end else if (busy_r) begin
        for (int i = 0; i < AXES; i++) begin
          acc_r[i] <= acc_nxt[i];
        end
        done_r <= done_nxt;
        if (last_w) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && has_result) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && has_result) begin
      out_data_r <= res_w;
    end
  end

endmodule

FILE: tb/sv/four_axis_step_interpolator_top_test.sv
`timescale 1ns / 1ps

module four_axis_step_interpolator_top_test;
  import fasi_pkg::*;

  localparam int STEP_BITS = STEP_BITS_DEF;
  localparam int CW = STEP_BITS + 3;
  localparam logic [63:0] STEP_LIMIT = (64'd1 << STEP_BITS) - 64'd1;
  localparam logic signed [LEN_W-1:0] ONE = 32'sh0001_0000;

  typedef logic signed [CW-1:0] steps_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  four_axis_step_interpolator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Interpolator state as the block should hold it.
  logic [SCALE_W-1:0] scale_reg;
  logic [REV_W-1:0] reverse_reg;
  steps_t move_steps[LEN_LANES];
  steps_t phase_acc[LEN_LANES];
  steps_t move_span;
  steps_t ticks_taken;
  logic [1:0] move_section;
  bit moving;

  out_item_t expected_ticks[$];

  int errors = 0;
  int requests_sent = 0;
  int loads_sent = 0;
  int ticks_sent = 0;
  int ticks_checked = 0;
  int settings_used = 0;
  bit quiet = 1'b0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  initial begin
    #2000000;
    $display("four_axis_step_interpolator_top_test: FAIL");
    $finish;
  end

  // Mostly short idle stretches, now and then a long one, none while quiet.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 20);
  endfunction

  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      hold = idle_len();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic steps_t scale_length(logic signed [LEN_W-1:0] len);
    logic [LEN_W-1:0] mag;
    logic [63:0] whole;
    mag = len[LEN_W-1] ? (~len + 32'd1) : len;
    whole = (64'(mag) * 64'(scale_reg)) >> 32;
    if (whole > STEP_LIMIT) whole = STEP_LIMIT;
    return len[LEN_W-1] ? -steps_t'(whole) : steps_t'(whole);
  endfunction

  task automatic predict_request(in_item_t req);
    logic signed [LEN_W-1:0] lens[LEN_LANES];
    steps_t c;
    steps_t m;
    steps_t a;
    int s;
    out_item_t r;
    if (req.opcode == OP_LOAD) begin
      loads_sent++;
      lens[0] = req.length_a;
      lens[1] = req.length_b;
      lens[2] = req.length_c;
      lens[3] = req.length_d;
      move_section = req.section;
      move_span = '0;
      for (int i = 0; i < LEN_LANES; i++) begin
        c = scale_length(lens[i]);
        m = (c < 0) ? -c : c;
        move_steps[i] = c;
        phase_acc[i] = '0;
        if (m > move_span) move_span = m;
      end
      ticks_taken = '0;
      moving = (move_span != 0);
    end else begin
      ticks_sent++;
      if (moving) begin
        r.enable_mask = (move_section == SECT_ALL) ? 3'b111 : (3'b001 << move_section);
        for (int i = 0; i < LEN_LANES; i++) begin
          a = phase_acc[i] + move_steps[i];
          s = 0;
          if (a >= move_span) begin
            s = 1;
            a = a - move_span;
          end else if (a < 0) begin
            s = -1;
            a = a + move_span;
          end
          phase_acc[i] = a;
          r.dir_mask[i] = reverse_reg[i] ? (s < 0) : (s >= 0);
          r.step_mask[i] = (s != 0);
        end
        ticks_taken = ticks_taken + steps_t'(1);
        r.last_step = (ticks_taken >= move_span);
        if (r.last_step) moving = 1'b0;
        expected_ticks.push_back(r);
      end
    end
  endtask

  function automatic bit field_ok(string name, logic [3:0] exp_v, logic [3:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    bit ok;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_ticks.size() == 0) begin
        $display("%0t: unexpected step result %0h, expected nothing", $time, out_data);
        errors++;
      end else begin
        want = expected_ticks.pop_front();
        ok = field_ok("enable_mask", 4'(want.enable_mask), 4'(out_data.enable_mask));
        ok &= field_ok("dir_mask", want.dir_mask, out_data.dir_mask);
        ok &= field_ok("step_mask", want.step_mask, out_data.step_mask);
        ok &= field_ok("last_step", 4'(want.last_step), 4'(out_data.last_step));
        if (!ok) errors++;
        ticks_checked++;
      end
    end
  end

  // Called at a falling edge; the request is held until the block takes it.
  task automatic send_request(in_item_t req);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(req);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    // A load still in the pipeline gives no result, so allow its latency.
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    settle_block();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_STEP_SCALE) scale_reg = value;
    else if (idx == REG_REVERSE_MASK) reverse_reg = value[REV_W-1:0];
    settings_used++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t load_item(logic [1:0] sect, logic signed [LEN_W-1:0] a,
                                         logic signed [LEN_W-1:0] b,
                                         logic signed [LEN_W-1:0] c,
                                         logic signed [LEN_W-1:0] d);
    in_item_t req;
    req.opcode = OP_LOAD;
    req.section = sect;
    req.length_a = a;
    req.length_b = b;
    req.length_c = c;
    req.length_d = d;
    return req;
  endfunction

  // Tick requests carry random length fields that the block must ignore.
  function automatic in_item_t tick_item();
    in_item_t req;
    req = load_item(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom);
    req.opcode = OP_TICK;
    return req;
  endfunction

  // Mostly lengths that give a handful of steps at the current scale.
  function automatic logic signed [LEN_W-1:0] random_length(int max_steps);
    logic [63:0] mag;
    int t;
    if ($urandom_range(0, 15) == 0) return $urandom;
    t = $urandom_range(0, max_steps);
    if (scale_reg == 0) mag = 64'($urandom >> 1);
    else mag = ((64'(t) << 32) + 64'($urandom)) / 64'(scale_reg);
    if (mag > 64'h7fff_ffff) mag = 64'h7fff_ffff;
    return $urandom_range(0, 1) ? -$signed(mag[31:0]) : $signed(mag[31:0]);
  endfunction

  task automatic run_ticks(int n);
    repeat (n) send_request(tick_item());
  endtask

  task automatic test_directed_cases();
    // A tick with no move loaded is dropped.
    run_ticks(1);
    // All lengths zero: nothing to do, the block stays idle.
    send_request(load_item(SECT_2, '0, '0, '0, '0));
    run_ticks(1);
    // Extreme lengths, abandoned after a few ticks by the next load.
    send_request(load_item(SECT_0, 32'sh7fff_ffff, 32'sh8000_0000, '0, 32'shffff_ffff));
    run_ticks(3);
    // Fractions truncate toward zero; runs to the end and one tick past it.
    send_request(load_item(SECT_ALL, 3 * ONE, -2 * ONE, ONE + ONE / 2, -ONE / 2));
    run_ticks(4);
    send_request(load_item(SECT_1, -ONE, '0, '0, 2 * ONE));
    run_ticks(1);
    send_request(load_item(SECT_2, 5 * ONE, -5 * ONE, 4 * ONE, -3 * ONE));
    run_ticks(5);
  endtask

  task automatic test_register_extremes();
    write_register(REG_STEP_SCALE, 32'hffff_ffff);
    write_register(REG_REVERSE_MASK, 32'hf);
    send_request(load_item(SECT_ALL, 32'sh7fff_ffff, 32'sh8000_0000, 32'sd5, -32'sd3));
    run_ticks(3);
    send_request(load_item(SECT_0, 32'sd5, -32'sd3, 32'sd2, -32'sd1));
    run_ticks(4);
    write_register(REG_STEP_SCALE, 32'h0);
    send_request(load_item(SECT_1, 32'sh7fff_ffff, 32'sh8000_0000, ONE, -ONE));
    run_ticks(1);
  endtask

  // Well-formed moves with random content, some cut short by a new load,
  // with stray ticks sprinkled in.
  task automatic test_random_moves(logic [31:0] scale, logic [3:0] rev, bit calm,
                                   int budget);
    int stop_at;
    int k;
    int lim;
    write_register(REG_STEP_SCALE, scale);
    write_register(REG_REVERSE_MASK, 32'(rev));
    quiet = calm;
    stop_at = requests_sent + budget;
    while (requests_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) run_ticks(1);
      lim = $urandom_range(1, 24);
      send_request(load_item(2'($urandom_range(0, 3)), random_length(lim), random_length(lim),
                             random_length(lim), random_length(lim)));
      if (move_span > 40 || $urandom_range(0, 5) == 0) k = $urandom_range(0, 12);
      else k = int'(move_span) + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
      run_ticks(k);
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_STEP_SCALE;
    cfg_data = '0;
    scale_reg = SCALE_RESET;
    reverse_reg = '0;
    for (int i = 0; i < LEN_LANES; i++) begin
      move_steps[i] = '0;
      phase_acc[i] = '0;
    end
    move_span = '0;
    ticks_taken = '0;
    move_section = SECT_0;
    moving = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_cases();
    test_register_extremes();
    test_random_moves(32'h0001_0000, 4'h0, 1'b0, 80);
    test_random_moves(32'hffff_ffff, 4'hf, 1'b1, 70);
    test_random_moves(32'h0000_8000, 4'($urandom), 1'b0, 70);
    test_random_moves(32'($urandom_range(4096, 1 << 20)), 4'($urandom), 1'b0, 70);
    test_random_moves(32'h0, 4'h5, 1'b0, 20);
    test_random_moves(32'h0003_0000, 4'ha, 1'b0, 70);

    in_valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Run covered %0d loads and %0d tick requests across %0d register writes,",
             loads_sent, ticks_sent, settings_used);
    $display("with %0d step results compared and %0d mismatches.", ticks_checked, errors);
    if (errors == 0) begin
      $display("four_axis_step_interpolator_top_test: PASS");
    end else begin
      $display("four_axis_step_interpolator_top_test: FAIL");
    end
    $finish;
  end

endmodule
